// ===== src/crpc_pkg.sv =====
// Shared constants, phase codes, result type and hash step for the cache record parser.
package crpc_pkg;

   localparam logic [31:0] MAGIC_WORD = 32'h5256_4334;
   localparam logic [63:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;

   // parse phases
   localparam logic [4:0] PH_MAGIC   = 5'd0;
   localparam logic [4:0] PH_KEYLEN  = 5'd1;
   localparam logic [4:0] PH_KEY     = 5'd2;
   localparam logic [4:0] PH_STATUS  = 5'd3;
   localparam logic [4:0] PH_TIME0   = 5'd4;
   localparam logic [4:0] PH_TIME4   = 5'd8;
   localparam logic [4:0] PH_HDRCNT  = 5'd9;
   localparam logic [4:0] PH_NAMELEN = 5'd10;
   localparam logic [4:0] PH_NAME    = 5'd11;
   localparam logic [4:0] PH_VALLEN  = 5'd12;
   localparam logic [4:0] PH_VAL     = 5'd13;
   localparam logic [4:0] PH_BODYLEN = 5'd14;
   localparam logic [4:0] PH_BODY    = 5'd15;
   localparam logic [4:0] PH_CKSUM   = 5'd16;
   localparam logic [4:0] PH_DONE    = 5'd17;
   localparam logic [4:0] PH_ERROR   = 5'd18;

   // result kinds
   localparam logic [3:0] KIND_KEYBYTE = 4'd1;
   localparam logic [3:0] KIND_VERDICT = 4'd15;

   // verdict codes
   localparam logic [2:0] V_OK    = 3'd0;
   localparam logic [2:0] V_MAGIC = 3'd1;
   localparam logic [2:0] V_TRUNC = 3'd2;
   localparam logic [2:0] V_TRAIL = 3'd3;
   localparam logic [2:0] V_CKSUM = 3'd4;

   // result queue
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic        run_last;
   } result_type;

   // FNV-1a step: (h ^ b) * 0x100000001b3, written as shifts and adds
   function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // position of the final byte of a fixed-size field
   function automatic logic [2:0] last_pos(input logic [4:0] ph);
      logic [2:0] r;
      r = 3'd3;
      if (ph == PH_STATUS)
         r = 3'd1;
      else if ((ph >= PH_TIME0 && ph <= PH_TIME4) || ph == PH_BODYLEN || ph == PH_CKSUM)
         r = 3'd7;
      return r;
   endfunction

endpackage

// ===== src/cache_record_parser_checker.sv =====
// Cache record parser and checker: byte-wide record walk, FNV-1a check, tagged field results.
// A taken byte is registered, then parsed; its results are offered from the result queue.
// Throughput: one byte per cycle, bounded by the hash update loop, while the queue has room.
// A byte yields at most two results (a field and the verdict) into a four-entry result queue.
// Reset (synchronous): parser state cleared, hash at the FNV basis, full_decode set to 1.
module cache_record_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [3:0]  rsp_tuser,   // [3:0] kind
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // full_decode
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // parser state
   logic        full_decode_ff;
   logic [4:0]  phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [63:0] asm_ff, asm_in;
   logic [63:0] left_ff, left_in;
   logic [31:0] hdrs_ff, hdrs_in;
   logic [63:0] hash_ff, hash_in;
   logic [2:0]  err_ff, err_in;

   // result queue
   crpc_pkg::result_type q_mem_ff [crpc_pkg::QDEPTH];
   logic [crpc_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [crpc_pkg::QCNT_W-1:0] q_cnt_ff;

   logic        adv;
   logic        pop;
   logic        fld_emit;
   logic        fld_ok;
   logic [3:0]  fld_kind;
   logic [63:0] fld_value;
   logic [63:0] asm_word;
   logic [2:0]  verdict;
   logic [1:0]  push_n;
   crpc_pkg::result_type ent0, ent1;

   // parse the held word only when the queue has room for both possible results
   assign adv        = in_valid_ff && (q_cnt_ff <= crpc_pkg::QCNT_W'(crpc_pkg::QDEPTH - 2));
   assign req_tready = !in_valid_ff || adv;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = (q_cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = q_mem_ff[rd_ptr_ff].value;
   assign rsp_tuser  = q_mem_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = q_mem_ff[rd_ptr_ff].run_last;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      asm_in    = asm_ff;
      left_in   = left_ff;
      hdrs_in   = hdrs_ff;
      hash_in   = hash_ff;
      err_in    = err_ff;
      fld_emit  = 1'b0;
      fld_kind  = 4'(phase_ff - 5'd1);
      fld_value = '0;
      verdict   = crpc_pkg::V_OK;
      asm_word  = asm_ff;
      asm_word[{pos_ff, 3'b000} +: 8] = in_byte_ff;

      if (adv) begin
         if (phase_ff < crpc_pkg::PH_CKSUM)
            hash_in = crpc_pkg::hash_step(hash_ff, in_byte_ff);

         case (phase_ff) inside
            crpc_pkg::PH_KEY, crpc_pkg::PH_NAME, crpc_pkg::PH_VAL, crpc_pkg::PH_BODY: begin
               fld_emit  = 1'b1;
               fld_value = {56'd0, in_byte_ff};
               left_in   = left_ff - 64'd1;
               if (left_ff == 64'd1) begin
                  case (phase_ff)
                     crpc_pkg::PH_KEY:  phase_in = crpc_pkg::PH_STATUS;
                     crpc_pkg::PH_NAME: phase_in = crpc_pkg::PH_VALLEN;
                     crpc_pkg::PH_VAL: begin
                        hdrs_in  = hdrs_ff - 32'd1;
                        phase_in = (hdrs_ff != 32'd1) ? crpc_pkg::PH_NAMELEN
                                                      : crpc_pkg::PH_BODYLEN;
                     end
                     default:           phase_in = crpc_pkg::PH_CKSUM;
                  endcase
               end
            end
            crpc_pkg::PH_DONE: begin
               err_in   = crpc_pkg::V_TRAIL;
               phase_in = crpc_pkg::PH_ERROR;
            end
            crpc_pkg::PH_ERROR: begin
               // bytes ignored until the final one
            end
            default: begin
               // fixed-size little-endian field
               asm_in = asm_word;
               pos_in = pos_ff + 3'd1;
               if (pos_ff == crpc_pkg::last_pos(phase_ff)) begin
                  pos_in = '0;
                  asm_in = '0;
                  case (phase_ff)
                     crpc_pkg::PH_MAGIC: begin
                        if (asm_word[31:0] != crpc_pkg::MAGIC_WORD) begin
                           err_in   = crpc_pkg::V_MAGIC;
                           phase_in = crpc_pkg::PH_ERROR;
                        end else begin
                           phase_in = crpc_pkg::PH_KEYLEN;
                        end
                     end
                     crpc_pkg::PH_CKSUM: begin
                        err_in   = (asm_word == hash_ff) ? crpc_pkg::V_OK : crpc_pkg::V_CKSUM;
                        phase_in = crpc_pkg::PH_DONE;
                     end
                     crpc_pkg::PH_KEYLEN, crpc_pkg::PH_NAMELEN,
                     crpc_pkg::PH_VALLEN, crpc_pkg::PH_BODYLEN: begin
                        fld_emit  = 1'b1;
                        fld_value = asm_word;
                        left_in   = asm_word;
                        if (asm_word != 64'd0) begin
                           phase_in = phase_ff + 5'd1;
                        end else begin
                           case (phase_ff)
                              crpc_pkg::PH_KEYLEN:  phase_in = crpc_pkg::PH_STATUS;
                              crpc_pkg::PH_NAMELEN: phase_in = crpc_pkg::PH_VALLEN;
                              crpc_pkg::PH_VALLEN: begin
                                 hdrs_in  = hdrs_ff - 32'd1;
                                 phase_in = (hdrs_ff != 32'd1) ? crpc_pkg::PH_NAMELEN
                                                               : crpc_pkg::PH_BODYLEN;
                              end
                              default:              phase_in = crpc_pkg::PH_CKSUM;
                           endcase
                        end
                     end
                     crpc_pkg::PH_HDRCNT: begin
                        fld_emit  = 1'b1;
                        fld_value = asm_word;
                        hdrs_in   = asm_word[31:0];
                        phase_in  = (asm_word[31:0] != 32'd0) ? crpc_pkg::PH_NAMELEN
                                                              : crpc_pkg::PH_BODYLEN;
                     end
                     default: begin
                        // status and time fields run in order
                        fld_emit  = 1'b1;
                        fld_value = asm_word;
                        phase_in  = phase_ff + 5'd1;
                     end
                  endcase
               end
            end
         endcase

         if (in_last_ff) begin
            verdict  = (phase_in == crpc_pkg::PH_DONE || phase_in == crpc_pkg::PH_ERROR)
                       ? err_in : crpc_pkg::V_TRUNC;
            phase_in = crpc_pkg::PH_MAGIC;
            pos_in   = '0;
            asm_in   = '0;
            left_in  = '0;
            hdrs_in  = '0;
            hash_in  = crpc_pkg::HASH_BASIS;
            err_in   = crpc_pkg::V_OK;
         end
      end
   end

   // in reduced mode only key length and key bytes go out as fields, besides the verdict
   assign fld_ok = fld_emit && ((fld_kind <= crpc_pkg::KIND_KEYBYTE) || full_decode_ff);
   assign push_n = adv ? ({1'b0, fld_ok} + {1'b0, in_last_ff}) : 2'd0;

   always_comb begin
      ent1.kind     = crpc_pkg::KIND_VERDICT;
      ent1.value    = {61'd0, verdict};
      ent1.run_last = 1'b1;
      if (fld_ok) begin
         ent0.kind     = fld_kind;
         ent0.value    = fld_value;
         ent0.run_last = !in_last_ff;
      end else begin
         ent0 = ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         full_decode_ff <= 1'b1;
         phase_ff       <= crpc_pkg::PH_MAGIC;
         pos_ff         <= '0;
         asm_ff         <= '0;
         left_ff        <= '0;
         hdrs_ff        <= '0;
         hash_ff        <= crpc_pkg::HASH_BASIS;
         err_ff         <= crpc_pkg::V_OK;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         q_cnt_ff       <= '0;
      end else begin
         if (csr_valid)
            full_decode_ff <= csr_data;
         if (req_tready)
            in_valid_ff <= req_tvalid;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         asm_ff    <= asm_in;
         left_ff   <= left_in;
         hdrs_ff   <= hdrs_in;
         hash_ff   <= hash_in;
         err_ff    <= err_in;
         wr_ptr_ff <= wr_ptr_ff + crpc_pkg::QPTR_W'(push_n);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         q_cnt_ff <= q_cnt_ff + crpc_pkg::QCNT_W'(push_n) - crpc_pkg::QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (push_n != 2'd0)
         q_mem_ff[wr_ptr_ff] <= ent0;
      if (push_n == 2'd2)
         q_mem_ff[wr_ptr_ff + 1'b1] <= ent1;
   end

endmodule

// ===== tb/sv/cache_record_parser_checker_tb.sv =====
// Self-checking testbench for the cache record parser: record stimulus, FNV-1a predictor, checks.
module cache_record_parser_checker_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
   localparam int unsigned WATCHDOG    = 200000;
   localparam int unsigned CHUNK_BYTES = 190;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;    // verdict below is typed in, not predicted
      logic [2:0] code;
   } stim_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   // predictor state
   bit          full_dec;
   logic [4:0]  phase;
   logic [2:0]  bpos;
   logic [63:0] word_acc;
   logic [63:0] left_in_field;
   logic [31:0] hdrs_left;
   logic [63:0] hash;
   logic [2:0]  verdict;

   crpc_pkg::result_type step_out[$];
   crpc_pkg::result_type pending_results[$];
   stim_word_type stim_q[$];
   stim_word_type dir_tab [23];
   logic [63:0] gen_hash;
   int unsigned items_sent = 0;
   int unsigned errors = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 0;
   logic        quiet;

   assign quiet = items_sent >= 520 && items_sent < 680;

   cache_record_parser_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME;
   endfunction

   task automatic clear_record();
      phase = crpc_pkg::PH_MAGIC;
      bpos = 3'd0;
      word_acc = 64'd0;
      left_in_field = 64'd0;
      hdrs_left = 32'd0;
      hash = crpc_pkg::HASH_BASIS;
      verdict = crpc_pkg::V_OK;
   endtask

   task automatic add_result(input logic [3:0] kind, input logic [63:0] value);
      crpc_pkg::result_type r;
      if (kind > crpc_pkg::KIND_KEYBYTE && kind != crpc_pkg::KIND_VERDICT && !full_dec)
         return;
      r = '{kind, value, 1'b0};
      step_out.insert(step_out.size(), r);
   endtask

   task automatic next_header();
      hdrs_left = hdrs_left - 32'd1;
      phase = (hdrs_left != 0) ? crpc_pkg::PH_NAMELEN : crpc_pkg::PH_BODYLEN;
   endtask

   // one byte through the record walk; results land in step_out
   task automatic parse_byte(input logic [7:0] b, input logic l);
      logic [4:0]  ph;
      logic [63:0] v;
      int          need;
      ph = phase;
      if (ph < crpc_pkg::PH_CKSUM)
         hash = fnv_mix(hash, b);
      if (ph == crpc_pkg::PH_KEY || ph == crpc_pkg::PH_NAME || ph == crpc_pkg::PH_VAL
          || ph == crpc_pkg::PH_BODY) begin
         add_result(4'(ph - 5'd1), {56'd0, b});
         left_in_field = left_in_field - 64'd1;
         if (left_in_field == 0) begin
            if (ph == crpc_pkg::PH_KEY) phase = crpc_pkg::PH_STATUS;
            else if (ph == crpc_pkg::PH_NAME) phase = crpc_pkg::PH_VALLEN;
            else if (ph == crpc_pkg::PH_VAL) next_header();
            else phase = crpc_pkg::PH_CKSUM;
         end
      end else if (ph == crpc_pkg::PH_DONE) begin
         verdict = crpc_pkg::V_TRAIL;
         phase = crpc_pkg::PH_ERROR;
      end else if (ph < crpc_pkg::PH_DONE) begin
         need = (ph == crpc_pkg::PH_STATUS) ? 2 :
                ((ph >= crpc_pkg::PH_TIME0 && ph <= crpc_pkg::PH_TIME4)
                 || ph == crpc_pkg::PH_BODYLEN || ph == crpc_pkg::PH_CKSUM) ? 8 : 4;
         word_acc = word_acc | ({56'd0, b} << (8 * bpos));
         bpos = bpos + 3'd1;
         if (bpos == 0 || bpos >= need) begin
            v = word_acc;
            bpos = 3'd0;
            word_acc = 64'd0;
            if (ph == crpc_pkg::PH_MAGIC) begin
               if (v != {32'd0, crpc_pkg::MAGIC_WORD}) begin
                  verdict = crpc_pkg::V_MAGIC;
                  phase = crpc_pkg::PH_ERROR;
               end else begin
                  phase = crpc_pkg::PH_KEYLEN;
               end
            end else if (ph == crpc_pkg::PH_CKSUM) begin
               verdict = (v == hash) ? crpc_pkg::V_OK : crpc_pkg::V_CKSUM;
               phase = crpc_pkg::PH_DONE;
            end else begin
               add_result(4'(ph - 5'd1), v);
               if (ph == crpc_pkg::PH_KEYLEN || ph == crpc_pkg::PH_NAMELEN
                   || ph == crpc_pkg::PH_VALLEN || ph == crpc_pkg::PH_BODYLEN) begin
                  left_in_field = v;
                  if (v != 0) phase = ph + 5'd1;
                  else if (ph == crpc_pkg::PH_KEYLEN) phase = crpc_pkg::PH_STATUS;
                  else if (ph == crpc_pkg::PH_NAMELEN) phase = crpc_pkg::PH_VALLEN;
                  else if (ph == crpc_pkg::PH_VALLEN) next_header();
                  else phase = crpc_pkg::PH_CKSUM;
               end else if (ph == crpc_pkg::PH_HDRCNT) begin
                  hdrs_left = v[31:0];
                  phase = (hdrs_left != 0) ? crpc_pkg::PH_NAMELEN : crpc_pkg::PH_BODYLEN;
               end else begin
                  phase = ph + 5'd1;
               end
            end
         end
      end
      if (l) begin
         add_result(crpc_pkg::KIND_VERDICT,
                    {61'd0, (phase == crpc_pkg::PH_DONE || phase == crpc_pkg::PH_ERROR)
                            ? verdict : crpc_pkg::V_TRUNC});
         clear_record();
      end
      if (step_out.size() != 0)
         step_out[$].run_last = 1'b1;
   endtask

   // record builder
   task automatic put_le(input logic [63:0] v, input int nb);
      stim_word_type w;
      for (int i = 0; i < nb; i++) begin
         w = '{v[8*i +: 8], 1'b0, 1'b0, crpc_pkg::V_OK};
         stim_q.insert(stim_q.size(), w);
         gen_hash = fnv_mix(gen_hash, v[8*i +: 8]);
      end
   endtask

   task automatic put_junk(input int nb);
      for (int i = 0; i < nb; i++)
         put_le(64'($urandom_range(0, 255)), 1);
   endtask

   task automatic cut_short();
      put_junk($urandom_range(1, 6));
      stim_q[$].last = 1'b1;
   endtask

   // mostly well-formed records; some carry a bad checksum, trailing bytes,
   // an early end, an absurd length or a broken magic word
   task automatic build_record();
      int          mode;
      int          which;
      int          first;
      int          nh;
      int          cut;
      logic [63:0] len;
      logic [63:0] huge;
      mode = $urandom_range(0, 99);
      which = (mode >= 86 && mode < 94) ? $urandom_range(0, 4) : 5;
      huge = {$urandom, $urandom | 32'h100};
      first = stim_q.size();
      gen_hash = crpc_pkg::HASH_BASIS;
      if (mode >= 94) begin
         put_le({32'd0, crpc_pkg::MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31))}, 4);
         put_junk($urandom_range(0, 5));
         stim_q[$].last = 1'b1;
         return;
      end
      put_le({32'd0, crpc_pkg::MAGIC_WORD}, 4);
      len = (which == 0) ? huge : 64'($urandom_range(0, 4));
      put_le(len, 4);
      if (which == 0) begin
         cut_short();
         return;
      end
      put_junk(int'(len));
      put_le(64'($urandom_range(0, 65535)), 2);
      for (int t = 0; t < 5; t++) begin
         case ($urandom_range(0, 9))
            0: put_le(64'd0, 8);
            1: put_le({64{1'b1}}, 8);
            default: put_le({$urandom, $urandom}, 8);
         endcase
      end
      if (which == 1) begin
         put_le(huge, 4);
         cut_short();
         return;
      end
      nh = $urandom_range(0, 2);
      put_le(64'(nh), 4);
      for (int h = 0; h < nh; h++) begin
         len = (which == 2) ? huge : 64'($urandom_range(0, 3));
         put_le(len, 4);
         if (which == 2) begin
            cut_short();
            return;
         end
         put_junk(int'(len));
         len = (which == 3) ? huge : 64'($urandom_range(0, 3));
         put_le(len, 4);
         if (which == 3) begin
            cut_short();
            return;
         end
         put_junk(int'(len));
      end
      len = (which == 4) ? huge : 64'($urandom_range(0, 5));
      put_le(len, 8);
      if (which == 4) begin
         cut_short();
         return;
      end
      put_junk(int'(len));
      if (mode >= 60 && mode < 68)
         put_le(gen_hash ^ (64'd1 << $urandom_range(0, 63)), 8);
      else
         put_le(gen_hash, 8);
      if (mode >= 68 && mode < 76)
         put_junk($urandom_range(1, 3));
      if (mode >= 76 && mode < 86) begin
         cut = $urandom_range(first, stim_q.size() - 2);
         while (stim_q.size() > cut + 1)
            void'(stim_q.pop_back());
      end
      stim_q[$].last = 1'b1;
   endtask

   task automatic send_all();
      stim_word_type w;
      while (stim_q.size() != 0) begin
         w = stim_q.pop_front();
         while (!quiet && $urandom_range(0, 99) < 33) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata = w.data;
         req_tlast = w.last;
         do @(posedge clock); while (!req_tready);
         parse_byte(w.data, w.last);
         if (w.typed)
            step_out[$] = '{crpc_pkg::KIND_VERDICT, {61'd0, w.code}, 1'b1};
         foreach (step_out[i])
            pending_results.insert(pending_results.size(), step_out[i]);
         step_out.delete();
         items_sent++;
         @(negedge clock);
      end
      req_tvalid = 1'b0;
   endtask

   task automatic run_random(input int unsigned nbytes);
      int n;
      stim_word_type w;
      while (stim_q.size() < nbytes) begin
         if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               w = '{8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     1'b0, crpc_pkg::V_OK};
               stim_q.insert(stim_q.size(), w);
            end
            stim_q[$].last = 1'b1;
         end else begin
            build_record();
         end
      end
      send_all();
   endtask

   // register writes only once the parser has gone quiet
   task automatic write_mode(input logic mode);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = mode;
      do @(posedge clock); while (!csr_ready);
      full_dec = mode;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (!hold_done && items_sent >= 350) begin
         hold_left = 300;
         hold_done = 1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 33);
      end
   end

   always @(posedge clock) begin
      crpc_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word kind=%0d value=%h last=%0b",
                     $realtime, rsp_tuser, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.value
                || rsp_tlast !== want.run_last) begin
               $display("%0t: expected %0d/%h/%0b, actual %0d/%h/%0b",
                        $realtime, want.kind, want.value, want.run_last,
                        rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < WATCHDOG) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      // short records after reset: early ends, broken magic, first key fields
      dir_tab = '{
         {8'hFF, 1'b1, 1'b1, crpc_pkg::V_TRUNC},
         {8'h00, 1'b1, 1'b1, crpc_pkg::V_TRUNC},
         {8'h34, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h43, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h56, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b1, 1'b1, crpc_pkg::V_MAGIC},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'hFF, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h80, 1'b1, 1'b1, crpc_pkg::V_MAGIC},
         {8'h34, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h43, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h56, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h52, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h01, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h00, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'hAB, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'h07, 1'b0, 1'b0, crpc_pkg::V_OK},
         {8'hFF, 1'b1, 1'b1, crpc_pkg::V_TRUNC}
      };
      full_dec = 1'b1;
      clear_record();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_mode(1'b1);
      foreach (dir_tab[i])
         stim_q.insert(stim_q.size(), dir_tab[i]);
      send_all();
      write_mode(1'b0);
      run_random(CHUNK_BYTES);
      write_mode(1'b1);
      run_random(CHUNK_BYTES);
      write_mode(1'b0);
      run_random(CHUNK_BYTES);
      write_mode(1'b1);
      run_random(CHUNK_BYTES);

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/crpc_pkg.sv
src/cache_record_parser_checker.sv
tb/sv/cache_record_parser_checker_tb.sv
